### hw/rtl/clwt_pkg.sv
// Shared codes, widths and constants for the config log write throttle.
package clwt_pkg;

  localparam int unsigned SECTOR_W = 13;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned DAY_W    = 17;
  localparam int unsigned PROD_W   = TIME_W + DAY_W;
  localparam int unsigned RECIP_W  = 26;
  localparam int unsigned MUL_W    = TIME_W + RECIP_W;
  localparam int unsigned DAYS_W   = 16;

  typedef logic [1:0] op_t;
  typedef logic [2:0] action_t;
  typedef logic [2:0] reg_index_t;

  localparam op_t OP_SAVE  = 2'd0;
  localparam op_t OP_TICK  = 2'd1;
  localparam op_t OP_ADOPT = 2'd2;

  localparam action_t ACT_WRITTEN    = 3'd0;
  localparam action_t ACT_DEFERRED   = 3'd1;
  localparam action_t ACT_IDLE       = 3'd2;
  localparam action_t ACT_ADOPTED    = 3'd3;
  localparam action_t ACT_NOT_LOADED = 3'd4;
  localparam action_t ACT_NO_TIME    = 3'd5;
  localparam action_t ACT_AREA       = 3'd6;

  localparam reg_index_t REG_LOG_FIRST   = 3'd0;
  localparam reg_index_t REG_LOG_END     = 3'd1;
  localparam reg_index_t REG_SEED_SECTOR = 3'd2;
  localparam reg_index_t REG_SEED_ID     = 3'd3;
  localparam reg_index_t REG_SEED_FIRST  = 3'd4;
  localparam reg_index_t REG_SEED_LAST   = 3'd5;
  localparam reg_index_t REG_MAX_PER_DAY = 3'd6;

  localparam logic [DAY_W-1:0] DAY_SEC = 17'd86400;

  // A day is 675 << 7 seconds. ((now >> 7) * DAY_RECIP) >> 35 equals now / 86400
  // for every 32-bit now, since the reciprocal error stays below one part in 2^10.
  localparam int unsigned DAY_SHIFT   = 7;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] DAY_RECIP = 26'd50903317;

  localparam logic [SECTOR_W-1:0] SEED_SECTOR_RST = 13'h1000;
  localparam logic [RATE_W-1:0]   MAX_PER_DAY_RST = 16'd200;

endpackage

### hw/rtl/config_log_write_throttle.sv
// Wear-levelling write scheduler for a ring of flash sectors holding settings.
// Adopt, tick and most saves finish in EXEC; the rate test goes on through MUL_ID, MUL_LIM
// and CMP; a new deadline is made in DIV and DL (two passes through the shared multiplier),
// from EXEC or after the rate test. Throughput: one item in work; the next input beat is
// taken the cycle after the result is produced; an unaccepted result holds the next item back.
// Reset (synchronous) restores the register defaults, empties the log and drops any deadline.
module config_log_write_throttle #(
  parameter int unsigned SECTOR_COUNT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  clwt_pkg::reg_index_t                cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  clwt_pkg::op_t                       op,
  input  logic [clwt_pkg::TIME_W-1:0]         now_seconds,
  output logic                                out_valid,
  input  logic                                out_ready,
  output clwt_pkg::action_t                   action,
  output logic [11:0]                         sector,
  output logic [clwt_pkg::TIME_W-1:0]         record_id,
  output logic [clwt_pkg::TIME_W-1:0]         record_time,
  output logic [clwt_pkg::TIME_W-1:0]         record_first_time
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_MUL_ID  = 3'd2;
  localparam logic [2:0] ST_MUL_LIM = 3'd3;
  localparam logic [2:0] ST_CMP     = 3'd4;
  localparam logic [2:0] ST_DIV     = 3'd5;
  localparam logic [2:0] ST_DL      = 3'd6;

  localparam int unsigned SW = clwt_pkg::SECTOR_W;
  localparam int unsigned TW = clwt_pkg::TIME_W;
  localparam int unsigned PW = clwt_pkg::PROD_W;
  localparam int unsigned RW = clwt_pkg::RECIP_W;
  localparam int unsigned MW = clwt_pkg::MUL_W;

  // Configuration registers.
  logic [SW-1:0]              log_first_sector;
  logic [SW-1:0]              log_end_sector;
  logic [SW-1:0]              seed_sector;
  logic [TW-1:0]              seed_id;
  logic [TW-1:0]              seed_first_time;
  logic [TW-1:0]              seed_last_time;
  logic [clwt_pkg::RATE_W-1:0] max_per_day;

  // Log state.
  logic          loaded;
  logic [SW-1:0] current_sector;
  logic [TW-1:0] last_id;
  logic [TW-1:0] last_time;
  logic [TW-1:0] last_first_time;
  logic [TW-1:0] retry_deadline;

  logic [2:0]    state;
  logic [2:0]    state_next;

  // Item and working registers.
  clwt_pkg::op_t op_r;
  logic [TW-1:0] now_r;
  logic [PW-1:0] lhs;
  logic [PW-1:0] prod;
  logic [clwt_pkg::DAYS_W-1:0] dq;

  // Shared multiplier.
  logic [TW-1:0] mul_a;
  logic [RW-1:0] mul_b;
  logic [MW-1:0] mul_p;

  logic          out_free;
  logic          area_ok;
  logic [SW-1:0] nxt_inc;
  logic [SW-1:0] nxt;
  logic [TW-1:0] first_c;
  logic [TW-1:0] id_c;
  logic [TW-1:0] wr_first;
  logic [TW-1:0] span;
  logic          tick_due;

  logic              fin;
  clwt_pkg::action_t fin_act;
  logic              wr_req;
  logic              commit;
  logic              adopt_go;
  logic              dl_clear;
  logic              dl_set;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign area_ok = (log_first_sector < log_end_sector) &&
                   ({4'b0, log_end_sector} <= 17'(SECTOR_COUNT));
  assign nxt_inc = current_sector + 13'd1;
  assign nxt     = (nxt_inc < log_first_sector || nxt_inc >= log_end_sector) ?
                   log_first_sector : nxt_inc;

  assign first_c  = (last_first_time != '0) ? last_first_time : now_r;
  assign id_c     = last_id + 32'd1;
  assign wr_first = (op_r == clwt_pkg::OP_SAVE) ? first_c : last_first_time;
  assign span     = now_r - first_c;
  assign tick_due = (now_r != '0) && (retry_deadline != '0) && (now_r >= retry_deadline);

  // Products for the rate test, the day count (reciprocal multiply) and the deadline (a second pass).
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_ID: begin
        mul_a = id_c;
        mul_b = RW'(clwt_pkg::DAY_SEC);
      end
      ST_MUL_LIM: begin
        mul_a = span;
        mul_b = RW'(max_per_day) + 26'd1;
      end
      ST_DIV: begin
        mul_a = TW'(now_r[TW-1:clwt_pkg::DAY_SHIFT]);
        mul_b = clwt_pkg::DAY_RECIP;
      end
      ST_DL: begin
        mul_a = TW'(dq) + 32'd1;
        mul_b = RW'(clwt_pkg::DAY_SEC);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MW'(mul_a) * MW'(mul_b);

  // Sequencer decisions. The quotient id * day / span exceeds the limit exactly
  // when id * day >= (limit + 1) * span, so no wide division is needed there.
  always_comb begin
    state_next = state;
    fin        = 1'b0;
    fin_act    = clwt_pkg::ACT_IDLE;
    wr_req     = 1'b0;
    adopt_go   = 1'b0;
    dl_clear   = 1'b0;
    dl_set     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
          fin        = 1'b1;
          unique case (op_r)
            clwt_pkg::OP_ADOPT: begin
              if (area_ok) begin
                adopt_go = 1'b1;
                fin_act  = clwt_pkg::ACT_ADOPTED;
              end else begin
                fin_act = clwt_pkg::ACT_AREA;
              end
            end
            clwt_pkg::OP_TICK: begin
              if (tick_due) begin
                dl_clear = 1'b1;
                wr_req   = loaded;
              end
            end
            clwt_pkg::OP_SAVE: begin
              if (!loaded) begin
                fin_act = clwt_pkg::ACT_NOT_LOADED;
              end else if (now_r == '0 && last_time == '0) begin
                fin_act = clwt_pkg::ACT_NO_TIME;
              end else if (now_r == '0 || (now_r == first_c && id_c == '0)) begin
                wr_req = 1'b1;
              end else if (now_r <= first_c || id_c == '1) begin
                if (retry_deadline != '0) begin
                  fin_act = clwt_pkg::ACT_DEFERRED;
                end else begin
                  fin        = 1'b0;
                  state_next = ST_DIV;
                end
              end else begin
                fin        = 1'b0;
                state_next = ST_MUL_ID;
              end
            end
            default: begin
              fin_act = clwt_pkg::ACT_IDLE;
            end
          endcase
        end
      end
      ST_MUL_ID: begin
        state_next = ST_MUL_LIM;
      end
      ST_MUL_LIM: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (lhs >= prod) begin
          if (retry_deadline != '0) begin
            fin        = 1'b1;
            fin_act    = clwt_pkg::ACT_DEFERRED;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_DIV;
          end
        end else begin
          fin        = 1'b1;
          wr_req     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        state_next = ST_DL;
      end
      ST_DL: begin
        dl_set     = 1'b1;
        fin        = 1'b1;
        fin_act    = clwt_pkg::ACT_DEFERRED;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (wr_req) begin
      fin_act = area_ok ? clwt_pkg::ACT_WRITTEN : clwt_pkg::ACT_AREA;
    end
  end

  assign commit = wr_req && area_ok;

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      log_first_sector <= '0;
      log_end_sector   <= '0;
      seed_sector      <= clwt_pkg::SEED_SECTOR_RST;
      seed_id          <= '1;
      seed_first_time  <= '0;
      seed_last_time   <= '0;
      max_per_day      <= clwt_pkg::MAX_PER_DAY_RST;
      loaded           <= 1'b0;
      current_sector   <= '1;
      last_id          <= '1;
      last_time        <= '0;
      last_first_time  <= '0;
      retry_deadline   <= '0;
    end else begin
      state <= state_next;
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          clwt_pkg::REG_LOG_FIRST:   log_first_sector <= cfg_data[SW-1:0];
          clwt_pkg::REG_LOG_END:     log_end_sector   <= cfg_data[SW-1:0];
          clwt_pkg::REG_SEED_SECTOR: seed_sector      <= cfg_data[SW-1:0];
          clwt_pkg::REG_SEED_ID:     seed_id          <= cfg_data;
          clwt_pkg::REG_SEED_FIRST:  seed_first_time  <= cfg_data;
          clwt_pkg::REG_SEED_LAST:   seed_last_time   <= cfg_data;
          clwt_pkg::REG_MAX_PER_DAY: max_per_day      <= cfg_data[clwt_pkg::RATE_W-1:0];
          default: begin
          end
        endcase
      end
      if (adopt_go) begin
        loaded          <= 1'b1;
        current_sector  <= seed_sector;
        last_id         <= seed_id;
        last_first_time <= seed_first_time;
        last_time       <= seed_last_time;
      end
      if (commit) begin
        current_sector  <= nxt;
        last_id         <= id_c;
        last_time       <= now_r;
        last_first_time <= wr_first;
      end
      if (dl_clear) begin
        retry_deadline <= '0;
      end else if (dl_set) begin
        retry_deadline <= mul_p[TW-1:0];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= op;
      now_r <= now_seconds;
    end
    if (state == ST_MUL_ID) begin
      lhs <= mul_p[PW-1:0];
    end
    if (state == ST_MUL_LIM) begin
      prod <= mul_p[PW-1:0];
    end
    if (state == ST_DIV) begin
      dq <= mul_p[clwt_pkg::RECIP_SHIFT +: clwt_pkg::DAYS_W];
    end
    if (fin) begin
      action <= fin_act;
      if (commit) begin
        sector            <= nxt[11:0];
        record_id         <= id_c;
        record_time       <= now_r;
        record_first_time <= wr_first;
      end else begin
        sector            <= '0;
        record_id         <= '0;
        record_time       <= '0;
        record_first_time <= '0;
      end
    end
  end

endmodule

### tb/clwt_write_checker.sv
// Checker for the log write throttle: tracks registers and log state, predicts and compares.
`timescale 1ns / 100ps

module clwt_write_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  clwt_pkg::reg_index_t        cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  clwt_pkg::op_t               op,
  input  logic [31:0]                 now_seconds,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  clwt_pkg::action_t           action,
  input  logic [11:0]                 sector,
  input  logic [31:0]                 record_id,
  input  logic [31:0]                 record_time,
  input  logic [31:0]                 record_first_time,
  output int                          fail_count,
  output int                          pending,
  output int                          written_count,
  output int                          deferred_count
);

  localparam int          RING_LIMIT  = 4096;
  localparam logic [31:0] DAY_SECONDS = 32'(clwt_pkg::DAY_SEC);

  typedef struct packed {
    clwt_pkg::action_t action;
    logic [11:0]       sector;
    logic [31:0]       record_id;
    logic [31:0]       record_time;
    logic [31:0]       record_first_time;
  } log_result_t;

  log_result_t expected_records[$];

  // Register copies.
  logic [12:0] ring_first, ring_end, seed_sec;
  logic [31:0] seed_rec_id, seed_first, seed_last;
  logic [15:0] day_quota;

  // Log position and deferral state.
  logic        adopted;
  logic [12:0] ring_pos;
  logic [31:0] prev_id, prev_time, prev_first, deadline;

  initial begin
    fail_count     = 0;
    pending        = 0;
    written_count  = 0;
    deferred_count = 0;
  end

  function automatic logic ring_usable();
    return (ring_first < ring_end) && (int'(ring_end) <= RING_LIMIT);
  endfunction

  // Advances to the next ring sector and records what was written there, or reports an unusable ring.
  function automatic log_result_t commit_write(input logic [31:0] id, input logic [31:0] t,
                                               input logic [31:0] first_t);
    log_result_t r;
    logic [12:0] nxt;
    r = '0;
    if (!ring_usable()) begin
      r.action = clwt_pkg::ACT_AREA;
    end else begin
      nxt = ring_pos + 13'd1;
      if (nxt < ring_first || nxt >= ring_end) nxt = ring_first;
      ring_pos            = nxt;
      prev_id             = id;
      prev_time           = t;
      prev_first          = first_t;
      r.action            = clwt_pkg::ACT_WRITTEN;
      r.sector            = nxt[11:0];
      r.record_id         = id;
      r.record_time       = t;
      r.record_first_time = first_t;
    end
    return r;
  endfunction

  function automatic log_result_t predict_log_step(input clwt_pkg::op_t o,
                                                   input logic [31:0] now);
    log_result_t r;
    logic [31:0] first_t, id, span;
    logic [63:0] per_day;
    logic        too_fast;
    r = '0;
    r.action = clwt_pkg::ACT_IDLE;
    case (o)
      clwt_pkg::OP_ADOPT: begin
        if (!ring_usable()) begin
          r.action = clwt_pkg::ACT_AREA;
        end else begin
          adopted    = 1'b1;
          ring_pos   = seed_sec;
          prev_id    = seed_rec_id;
          prev_first = seed_first;
          prev_time  = seed_last;
          r.action   = clwt_pkg::ACT_ADOPTED;
        end
      end
      clwt_pkg::OP_TICK: begin
        if (now != 0 && deadline != 0 && now >= deadline) begin
          deadline = '0;
          if (adopted) r = commit_write(prev_id + 32'd1, now, prev_first);
        end
      end
      clwt_pkg::OP_SAVE: begin
        if (!adopted) begin
          r.action = clwt_pkg::ACT_NOT_LOADED;
        end else if (now == 0 && prev_time == 0) begin
          r.action = clwt_pkg::ACT_NO_TIME;
        end else begin
          first_t = (prev_first != 0) ? prev_first : now;
          id      = prev_id + 32'd1;
          span    = now - first_t;
          // The quotient is kept at full width; only then compared with the quota.
          if (now == first_t && id == 0) begin
            too_fast = 1'b0;
          end else if (now <= first_t || id == '1) begin
            too_fast = 1'b1;
          end else begin
            per_day  = ({32'd0, id} * 64'd86400) / {32'd0, span};
            too_fast = per_day > {48'd0, day_quota};
          end
          if (now != 0 && too_fast) begin
            if (deadline == 0) deadline = (now / DAY_SECONDS + 32'd1) * DAY_SECONDS;
            r.action = clwt_pkg::ACT_DEFERRED;
          end else begin
            r = commit_write(id, now, first_t);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    log_result_t want;
    if (rst) begin
      ring_first  = '0;
      ring_end    = '0;
      seed_sec    = clwt_pkg::SEED_SECTOR_RST;
      seed_rec_id = '1;
      seed_first  = '0;
      seed_last   = '0;
      day_quota   = clwt_pkg::MAX_PER_DAY_RST;
      adopted     = 1'b0;
      ring_pos    = '1;
      prev_id     = '1;
      prev_time   = '0;
      prev_first  = '0;
      deadline    = '0;
      expected_records.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          clwt_pkg::REG_LOG_FIRST:   ring_first  = cfg_data[12:0];
          clwt_pkg::REG_LOG_END:     ring_end    = cfg_data[12:0];
          clwt_pkg::REG_SEED_SECTOR: seed_sec    = cfg_data[12:0];
          clwt_pkg::REG_SEED_ID:     seed_rec_id = cfg_data;
          clwt_pkg::REG_SEED_FIRST:  seed_first  = cfg_data;
          clwt_pkg::REG_SEED_LAST:   seed_last   = cfg_data;
          clwt_pkg::REG_MAX_PER_DAY: day_quota   = cfg_data[15:0];
          default: ;
        endcase
      end
      // The result beat is matched before this edge's request is predicted.
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, expected none, actual %0d",
                   $time, action);
        end else begin
          want = expected_records.pop_front();
          check_field("action", 32'(want.action), 32'(action));
          check_field("sector", 32'(want.sector), 32'(sector));
          check_field("record_id", want.record_id, record_id);
          check_field("record_time", want.record_time, record_time);
          check_field("record_first_time", want.record_first_time, record_first_time);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_log_step(op, now_seconds);
        if (want.action == clwt_pkg::ACT_WRITTEN) written_count++;
        if (want.action == clwt_pkg::ACT_DEFERRED) deferred_count++;
        expected_records.push_back(want);
      end
      pending = expected_records.size();
    end
  end

endmodule

### tb/tb_top.sv
// Top of the log write throttle testbench: clock, reset, stimulus, back pressure and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int                   ITEM_TARGET    = 1300;
  localparam int                   WATCHDOG_LIMIT = 2000;
  localparam clwt_pkg::op_t        OP_UNUSED      = 2'd3;
  localparam clwt_pkg::reg_index_t REG_UNUSED     = 3'd7;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_LONG, RX_PERIODIC} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  clwt_pkg::reg_index_t cfg_index = clwt_pkg::REG_LOG_FIRST;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  clwt_pkg::op_t        op = clwt_pkg::OP_SAVE;
  logic [31:0]          now_seconds = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  clwt_pkg::action_t    action;
  logic [11:0]          sector;
  logic [31:0]          record_id, record_time, record_first_time;

  int fail_count, pending, written_count, deferred_count;
  int items_sent = 0;
  int phases = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  rx_mode_t    rx_mode = RX_ALWAYS;
  int          rx_mode_left = 0;
  int          rx_stall_left = 0;
  logic [31:0] rx_cycle = '0;

  config_log_write_throttle u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .now_seconds(now_seconds),
    .out_valid(out_valid), .out_ready(out_ready), .action(action), .sector(sector),
    .record_id(record_id), .record_time(record_time), .record_first_time(record_first_time)
  );

  clwt_write_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .now_seconds(now_seconds),
    .out_valid(out_valid), .out_ready(out_ready), .action(action), .sector(sector),
    .record_id(record_id), .record_time(record_time), .record_first_time(record_first_time),
    .fail_count(fail_count), .pending(pending),
    .written_count(written_count), .deferred_count(deferred_count)
  );

  always #1 clk = ~clk;

  // Result side: switches at random between several stall patterns.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 32'd1;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(100, 600);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_LONG: begin
        if (rx_stall_left != 0) begin
          rx_stall_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall_left = $urandom_range(1, 25);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
      default: out_ready <= (rx_cycle[2:0] != 3'd0) && (rx_cycle[4:3] != 2'd2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat on any channel for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("config_log_write_throttle test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sends one request; requests go out in bursts separated by random gaps.
  task automatic issue(input clwt_pkg::op_t o, input logic [31:0] s);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid    <= 1'b1;
    op          <= o;
    now_seconds <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Waits until every request has produced its result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(input clwt_pkg::reg_index_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic random_config(output logic [31:0] start_s);
    logic [12:0] f, e, ss;
    logic [31:0] sid, base, sf, sl, quota, junk;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      f = 13'd0;
      e = 13'd4096;
    end else if (pick == 1) begin
      f = 13'($urandom_range(1, 4095));
      e = 13'($urandom_range(0, f));
    end else if (pick == 2) begin
      f = 13'($urandom_range(0, 4000));
      e = 13'($urandom_range(4097, 8191));
    end else if (pick == 3) begin
      f = 13'd4084;
      e = 13'd4096;
    end else begin
      f = 13'($urandom_range(0, 4080));
      e = f + 13'($urandom_range(1, 12));
    end
    case ($urandom_range(0, 4))
      0:       ss = e;
      1:       ss = 13'h1FFF;
      2:       ss = 13'($urandom);
      default: ss = f + 13'($urandom_range(0, (e > f) ? e - f - 1 : 0));
    endcase
    case ($urandom_range(0, 5))
      0:       sid = '1;
      1:       sid = 32'hFFFF_FFFE;
      2:       sid = $urandom;
      default: sid = $urandom_range(0, 2000);
    endcase
    base = ($urandom_range(0, 9) == 0) ? 32'hFFF0_0000 + $urandom_range(0, 32'h000F_FFFF)
                                       : $urandom_range(1, 32'hF000_0000);
    sf = ($urandom_range(0, 5) == 0) ? 32'd0 : base;
    sl = ($urandom_range(0, 5) == 0) ? 32'd0 : base + $urandom_range(0, 172800);
    case ($urandom_range(0, 6))
      0:       quota = 32'd0;
      1:       quota = 32'd65535;
      2:       quota = 32'd200;
      3:       quota = $urandom;
      default: quota = $urandom_range(1, 400);
    endcase
    // Bits above a register's width are sometimes set; they must be dropped.
    junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_E000) : 32'd0;
    write_reg(clwt_pkg::REG_LOG_FIRST, junk | {19'd0, f});
    write_reg(clwt_pkg::REG_LOG_END, junk | {19'd0, e});
    write_reg(clwt_pkg::REG_SEED_SECTOR, junk | {19'd0, ss});
    write_reg(clwt_pkg::REG_SEED_ID, sid);
    write_reg(clwt_pkg::REG_SEED_FIRST, sf);
    write_reg(clwt_pkg::REG_SEED_LAST, sl);
    write_reg(clwt_pkg::REG_MAX_PER_DAY, quota);
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    start_s = (sl != 0) ? sl : base;
  endtask

  initial begin
    logic [31:0] clock_s;
    int n, pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Reset registers leave the ring empty, so adopt is refused.
    issue(clwt_pkg::OP_SAVE, 32'd1000);
    issue(clwt_pkg::OP_TICK, 32'd0);
    issue(clwt_pkg::OP_ADOPT, 32'd0);
    issue(OP_UNUSED, 32'hFFFF_FFFF);
    drain();
    write_reg(clwt_pkg::REG_LOG_FIRST, 32'd0);
    write_reg(clwt_pkg::REG_LOG_END, 32'd4096);
    write_reg(clwt_pkg::REG_SEED_SECTOR, 32'd4095);
    write_reg(clwt_pkg::REG_SEED_ID, 32'd5);
    write_reg(clwt_pkg::REG_SEED_FIRST, 32'd1000);
    write_reg(clwt_pkg::REG_SEED_LAST, 32'd0);
    write_reg(clwt_pkg::REG_MAX_PER_DAY, 32'd200);
    cfg_valid <= 1'b0;
    issue(clwt_pkg::OP_ADOPT, 32'd0);
    issue(clwt_pkg::OP_SAVE, 32'd0);
    issue(clwt_pkg::OP_SAVE, 32'd865000);
    issue(clwt_pkg::OP_SAVE, 32'd0);
    // Time before the first write is too fast; the second deferral keeps the deadline.
    issue(clwt_pkg::OP_SAVE, 32'd500);
    issue(clwt_pkg::OP_SAVE, 32'd600);
    issue(clwt_pkg::OP_TICK, 32'd86399);
    issue(clwt_pkg::OP_TICK, 32'd86400);
    issue(clwt_pkg::OP_TICK, 32'd90000);
    drain();
    // Empty log: all-ones id and seed sector at the end of the ring.
    write_reg(clwt_pkg::REG_MAX_PER_DAY, 32'd0);
    write_reg(clwt_pkg::REG_SEED_ID, 32'hFFFF_FFFF);
    write_reg(clwt_pkg::REG_SEED_FIRST, 32'd0);
    write_reg(clwt_pkg::REG_SEED_LAST, 32'd0);
    write_reg(clwt_pkg::REG_SEED_SECTOR, 32'd4096);
    cfg_valid <= 1'b0;
    issue(clwt_pkg::OP_ADOPT, 32'd0);
    issue(clwt_pkg::OP_SAVE, 32'd5000);
    issue(clwt_pkg::OP_SAVE, 32'd5001);
    issue(clwt_pkg::OP_SAVE, 32'hFFFF_FFFF);
    drain();
    // Re-adopt keeps the pending deadline; the next id would be all ones.
    write_reg(clwt_pkg::REG_SEED_ID, 32'hFFFF_FFFE);
    write_reg(clwt_pkg::REG_SEED_FIRST, 32'd100);
    write_reg(clwt_pkg::REG_SEED_LAST, 32'd200);
    write_reg(clwt_pkg::REG_MAX_PER_DAY, 32'd65535);
    cfg_valid <= 1'b0;
    issue(clwt_pkg::OP_ADOPT, 32'd0);
    issue(clwt_pkg::OP_SAVE, 32'd300);
    issue(clwt_pkg::OP_TICK, 32'd86400);
    drain();
    // A rate far above 16 bits must still count as too fast.
    write_reg(clwt_pkg::REG_SEED_ID, 32'h7FFF_FFFF);
    write_reg(clwt_pkg::REG_SEED_FIRST, 32'd1000);
    cfg_valid <= 1'b0;
    issue(clwt_pkg::OP_ADOPT, 32'd0);
    issue(clwt_pkg::OP_SAVE, 32'd1001);
    issue(clwt_pkg::OP_TICK, 32'd86400);
    drain();
    // Deadline past the top of the time range wraps around.
    write_reg(clwt_pkg::REG_MAX_PER_DAY, 32'd0);
    cfg_valid <= 1'b0;
    issue(clwt_pkg::OP_SAVE, 32'hFFFF_FF00);
    issue(clwt_pkg::OP_TICK, 32'd63104);
    drain();
    // Ring end beyond the sector count.
    write_reg(clwt_pkg::REG_LOG_END, 32'd4097);
    cfg_valid <= 1'b0;
    issue(clwt_pkg::OP_ADOPT, 32'd0);
    issue(clwt_pkg::OP_SAVE, 32'd70000);
    issue(clwt_pkg::OP_TICK, 32'd86400);

    // Random phases: new register settings, mostly an adopt, then mostly saves and ticks
    // with time moving forward, mixed with zero or random times, adopts and unused ops.
    while (items_sent < ITEM_TARGET) begin
      drain();
      random_config(clock_s);
      phases++;
      if ($urandom_range(0, 9) != 0) issue(clwt_pkg::OP_ADOPT, $urandom);
      n = $urandom_range(10, 50);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        clock_s += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300000)
                                               : $urandom_range(0, 20000);
        if (pick < 55)
          issue(clwt_pkg::OP_SAVE, clock_s);
        else if (pick < 85)
          issue(clwt_pkg::OP_TICK, clock_s);
        else if (pick < 90)
          issue(($urandom_range(0, 1) == 0) ? clwt_pkg::OP_SAVE : clwt_pkg::OP_TICK, 32'd0);
        else if (pick < 94)
          issue(($urandom_range(0, 1) == 0) ? clwt_pkg::OP_SAVE : clwt_pkg::OP_TICK, $urandom);
        else if (pick < 97)
          issue(clwt_pkg::OP_ADOPT, $urandom);
        else
          issue(OP_UNUSED, $urandom);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d requests over %0d random register settings plus the directed cases.",
             items_sent, phases);
    $display("Predicted %0d sector writes and %0d deferred saves; %0d mismatches.",
             written_count, deferred_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("config_log_write_throttle test passed");
    end else begin
      $display("config_log_write_throttle test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/clwt_pkg.sv
hw/rtl/config_log_write_throttle.sv
tb/clwt_write_checker.sv
tb/tb_top.sv
